FILE: hdl/sbt_pkg.sv
// Shared types and constants for the software breakpoint table.
// Used by sbt_ctrl, sbt_datapath and sw_breakpoint_table.
package sbt_pkg;

  localparam int NumEntriesDefault = 16;
  localparam int MaskW             = 16;
  localparam int AddrW             = 32;
  localparam int FuncW             = 3;
  localparam int StatusW           = 2;
  localparam int FailW             = 5;
  localparam int InDataW           = 48;  // bp_address + install_fail_mask
  localparam int OutDataW          = 8;   // status + fail_count, byte padded

  typedef enum logic [1:0] {
    ENTRY_EMPTY   = 2'd0,
    ENTRY_SET     = 2'd1,
    ENTRY_ACTIVE  = 2'd2,
    ENTRY_REMOVED = 2'd3
  } entry_state_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EXISTS  = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef enum logic [FuncW-1:0] {
    FUNC_SET        = 3'd0,
    FUNC_REMOVE     = 3'd1,
    FUNC_ACTIVATE   = 3'd2,
    FUNC_DEACTIVATE = 3'd3,
    FUNC_CLEAR      = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic start;   // latch request, clear scan trackers
    logic scan;    // walk the table
    logic commit;  // apply final write, load result register
  } sbt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sbt_stat_t;

endpackage

FILE: hdl/sbt_ctrl.sv
// Controller state machine for the software breakpoint table.
// Depends on sbt_pkg; drives sbt_datapath through sbt_cmd_t.
module sbt_ctrl
  import sbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  sbt_stat_t stat_i,
  output sbt_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.start = 1'b1;
          state_d     = CTRL_SCAN;
        end
      end
      CTRL_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = CTRL_FINISH;
        end
      end
      CTRL_FINISH: begin
        // hold until the result register can take the new response
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

endmodule

FILE: hdl/sbt_datapath.sv
// Datapath of the software breakpoint table: entry states, address memory,
// scan pipeline, match trackers and result register. Depends on sbt_pkg.
module sbt_datapath
  import sbt_pkg::*;
#(
  parameter int NUM_ENTRIES = NumEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbt_cmd_t            cmd_i,
  output sbt_stat_t           stat_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic [AddrW-1:0]    bp_address_i,
  input  logic [MaskW-1:0]    install_fail_mask_i,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int IdxW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CntW = $clog2(NUM_ENTRIES + 1);

  // entry table
  entry_state_e          entry_state_q [NUM_ENTRIES];
  logic [AddrW-1:0]      addr_mem [NUM_ENTRIES];

  // latched request
  logic [FuncW-1:0]      func_q;
  logic [AddrW-1:0]      addr_q;
  logic [MaskW-1:0]      mask_q;

  // scan pipeline
  logic [CntW-1:0]       cnt_q;
  logic                  pipe_vld_q;
  logic [IdxW-1:0]       cmp_idx_q;
  entry_state_e          cmp_state_q;
  logic [AddrW-1:0]      cmp_addr_q;
  logic                  issue;
  logic [IdxW-1:0]       rd_idx;

  // trackers
  logic                  found_set_q, found_rm_q, found_empty_q;
  logic [IdxW-1:0]       set_idx_q, rm_idx_q, empty_idx_q;
  logic [FailW-1:0]      fail_q;

  // state write port
  logic                  st_we;
  logic [IdxW-1:0]       st_widx;
  entry_state_e          st_wval;
  logic                  addr_we;

  // result
  logic                  out_valid_q;
  logic [StatusW-1:0]    out_status_q;
  logic [FailW-1:0]      out_fail_q;
  logic [StatusW-1:0]    res_status;
  logic [FailW-1:0]      res_fail;

  logic                  addr_hit;
  logic                  mask_bad;

  assign rd_idx = cnt_q[IdxW-1:0];
  assign issue  = cmd_i.scan && (cnt_q != CntW'(NUM_ENTRIES));

  assign addr_hit = (cmp_addr_q == addr_q);
  assign mask_bad = (32'(cmp_idx_q) < 32'(MaskW)) && mask_q[4'(cmp_idx_q)];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= func_i;
      addr_q <= bp_address_i;
      mask_q <= install_fail_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pipe_vld_q <= 1'b0;
    end else begin
      pipe_vld_q <= issue;
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // registered read of the addressed entry
  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_idx_q   <= rd_idx;
      cmp_state_q <= entry_state_q[rd_idx];
      cmp_addr_q  <= addr_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_set_q   <= 1'b0;
      found_rm_q    <= 1'b0;
      found_empty_q <= 1'b0;
      fail_q        <= '0;
    end else if (cmd_i.start) begin
      found_set_q   <= 1'b0;
      found_rm_q    <= 1'b0;
      found_empty_q <= 1'b0;
      fail_q        <= '0;
    end else if (pipe_vld_q) begin
      // keep the lowest matching index of each kind
      if (!found_set_q && cmp_state_q == ENTRY_SET && addr_hit) begin
        found_set_q <= 1'b1;
      end
      if (!found_rm_q && cmp_state_q == ENTRY_REMOVED && addr_hit) begin
        found_rm_q <= 1'b1;
      end
      if (!found_empty_q && cmp_state_q == ENTRY_EMPTY) begin
        found_empty_q <= 1'b1;
      end
      if (func_q == FUNC_ACTIVATE && cmp_state_q == ENTRY_SET && mask_bad) begin
        fail_q <= fail_q + FailW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_vld_q) begin
      if (!found_set_q) set_idx_q <= cmp_idx_q;
      if (!found_rm_q) rm_idx_q <= cmp_idx_q;
      if (!found_empty_q) empty_idx_q <= cmp_idx_q;
    end
  end

  // state updates from the scan and from the final commit
  always_comb begin
    st_we      = 1'b0;
    st_widx    = cmp_idx_q;
    st_wval    = ENTRY_EMPTY;
    addr_we    = 1'b0;
    res_status = STATUS_OK;
    res_fail   = '0;
    if (pipe_vld_q) begin
      priority if (func_q == FUNC_ACTIVATE) begin
        if (cmp_state_q == ENTRY_SET && !mask_bad) begin
          st_we   = 1'b1;
          st_wval = ENTRY_ACTIVE;
        end
      end else if (func_q == FUNC_DEACTIVATE) begin
        if (cmp_state_q == ENTRY_ACTIVE) begin
          st_we   = 1'b1;
          st_wval = ENTRY_SET;
        end
      end else if (func_q == FUNC_CLEAR) begin
        st_we   = 1'b1;
        st_wval = ENTRY_EMPTY;
      end else begin
      end
    end
    priority if (func_q == FUNC_SET) begin
      priority if (found_set_q) begin
        res_status = STATUS_EXISTS;
      end else if (found_rm_q) begin
        st_we   = cmd_i.commit;
        addr_we = cmd_i.commit;
        st_widx = rm_idx_q;
        st_wval = ENTRY_SET;
      end else if (found_empty_q) begin
        st_we   = cmd_i.commit;
        addr_we = cmd_i.commit;
        st_widx = empty_idx_q;
        st_wval = ENTRY_SET;
      end else begin
        res_status = STATUS_FULL;
      end
    end else if (func_q == FUNC_REMOVE) begin
      if (found_set_q) begin
        st_we   = cmd_i.commit;
        st_widx = set_idx_q;
        st_wval = ENTRY_REMOVED;
      end else begin
        res_status = STATUS_MISSING;
      end
    end else if (func_q == FUNC_ACTIVATE) begin
      res_fail = fail_q;
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entry_state_q[i] <= ENTRY_EMPTY;
      end
    end else if (st_we) begin
      entry_state_q[st_widx] <= st_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[st_widx] <= addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_fail_q   <= res_fail;
    end
  end

  assign stat_o.scan_done = (cnt_q == CntW'(NUM_ENTRIES)) && !pipe_vld_q;
  assign stat_o.out_free  = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_fail_q, out_status_q};

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten while stalled");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_fail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q <= FailW'(MaskW))
    else $error("failure count exceeds mask width");

endmodule

FILE: hdl/sw_breakpoint_table.sv
// Software breakpoint table, top level.
// Depends on sbt_pkg; instantiates sbt_ctrl and sbt_datapath.
//
// Usage: one request on the slave stream (s_axis_*) yields exactly one
// response on the master stream (m_axis_*). tuser carries the operation
// code; tdata carries the breakpoint address and the install-failure mask.
// The response tdata carries the status code and the activation failure
// count.
// Every request walks the whole table once through the entry read port,
// one entry per cycle; the next request is taken only after the response
// to the last one has been loaded into the output register.
// A finished response waits in the output register; if the receiver
// stalls, the next request is still accepted and scanned, then held until
// the register frees up. Reset marks every entry empty; stored addresses
// are not cleared, as they are only compared for set or removed entries.
module sw_breakpoint_table
  import sbt_pkg::*;
#(
  parameter int NUM_ENTRIES = NumEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [31:0] bp_address, [47:32] install_fail_mask
  input  logic [FuncW-1:0]    s_axis_tuser,   // [2:0] func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [1:0] status, [6:2] fail_count, [7] zero
);

  sbt_cmd_t  cmd;
  sbt_stat_t stat;

  sbt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  sbt_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .func_i              (s_axis_tuser),
    .bp_address_i        (s_axis_tdata[AddrW-1:0]),
    .install_fail_mask_i (s_axis_tdata[AddrW+MaskW-1:AddrW]),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tdata        (m_axis_tdata)
  );

endmodule

FILE: test/sw_breakpoint_table_tb.sv
// Self-checking testbench for sw_breakpoint_table: a directed table and random
// set/remove/activate/deactivate/clear traffic, checked against a shadow entry table.
// Depends on sbt_pkg and the sw_breakpoint_table RTL.
module sw_breakpoint_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbt_pkg::*;

  localparam int Entries     = NumEntriesDefault;
  localparam int PoolSize    = 24;
  localparam int PhaseItems  = 425;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 500000;
  localparam int NumDirected = 24;

  typedef struct {
    status_e              status;
    logic [FailW-1:0]     fails;
  } reply_t;

  typedef struct packed {
    logic [FuncW-1:0]     func;
    logic [AddrW-1:0]     addr;
    logic [MaskW-1:0]     mask;
    bit                   fixed;
    status_e              status;
    logic [FailW-1:0]     fails;
  } directed_row_t;

  // Rows marked fixed carry a hand-written reply; the others go through the shadow table.
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{FUNC_ACTIVATE,   32'h0000_0000, 16'hFFFF, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_REMOVE,     32'h0000_0000, 16'h0000, 1'b1, STATUS_MISSING, 5'd0},
    '{FUNC_DEACTIVATE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, STATUS_OK,      5'd0},
    '{3'd5,            32'h1234_5678, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{3'd6,            32'h0000_0000, 16'hAAAA, 1'b1, STATUS_OK,      5'd0},
    '{3'd7,            32'hFFFF_FFFF, 16'hFFFF, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_SET,        32'h0000_0000, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_SET,        32'hFFFF_FFFF, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_SET,        32'hFFFF_FFFF, 16'hFFFF, 1'b1, STATUS_EXISTS,  5'd0},
    '{FUNC_SET,        32'h0000_0000, 16'h0000, 1'b1, STATUS_EXISTS,  5'd0},
    '{FUNC_REMOVE,     32'h0000_0000, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_REMOVE,     32'h0000_0000, 16'h0000, 1'b1, STATUS_MISSING, 5'd0},
    '{FUNC_SET,        32'hA5A5_5A5A, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_SET,        32'h0000_0000, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_ACTIVATE,   32'h0000_0000, 16'h0001, 1'b0, STATUS_OK,      5'd0},
    '{FUNC_SET,        32'hFFFF_FFFF, 16'h0000, 1'b0, STATUS_OK,      5'd0},
    '{FUNC_REMOVE,     32'hFFFF_FFFF, 16'h0000, 1'b0, STATUS_OK,      5'd0},
    '{FUNC_REMOVE,     32'hFFFF_FFFF, 16'h0000, 1'b0, STATUS_OK,      5'd0},
    '{FUNC_ACTIVATE,   32'h0000_0000, 16'h0000, 1'b0, STATUS_OK,      5'd0},
    '{FUNC_DEACTIVATE, 32'h0000_0000, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_ACTIVATE,   32'h0000_0000, 16'hFFFF, 1'b0, STATUS_OK,      5'd0},
    '{FUNC_CLEAR,      32'h0000_0000, 16'h0000, 1'b1, STATUS_OK,      5'd0},
    '{FUNC_REMOVE,     32'h0000_0000, 16'h0000, 1'b1, STATUS_MISSING, 5'd0},
    '{FUNC_SET,        32'hFFFF_FFFF, 16'h0000, 1'b1, STATUS_OK,      5'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [31:0] bp_address, [47:32] install_fail_mask
  logic [FuncW-1:0]    s_axis_tuser = '0;   // [2:0] func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [1:0] status, [6:2] fail_count, [7] zero

  entry_state_e        tbl_state [Entries];
  logic [AddrW-1:0]    tbl_addr  [Entries];
  reply_t              outstanding_replies [$];
  logic [AddrW-1:0]    addr_pool [PoolSize];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int sent_count     = 0;
  int reply_count    = 0;
  int peak_fails     = 0;
  int status_seen [4];
  reply_t got_reply;

  sw_breakpoint_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               outstanding_replies.size());
      $display("** sw_breakpoint_table: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] reply %0d: %s got %0h expected %0h", $time, reply_count, what, got, want);
  endtask

  function automatic int find_slot(entry_state_e st, logic [AddrW-1:0] a, bit match_addr);
    for (int i = 0; i < Entries; i++) begin
      if (tbl_state[i] == st && (!match_addr || tbl_addr[i] == a))
        return i;
    end
    return -1;
  endfunction

  // Apply one operation to the shadow table and return the reply it yields.
  function automatic reply_t apply_table_op(logic [FuncW-1:0] f, logic [AddrW-1:0] a,
                                            logic [MaskW-1:0] m);
    reply_t r;
    int     slot;
    r.status = STATUS_OK;
    r.fails  = '0;
    case (f)
      FUNC_SET: begin
        if (find_slot(ENTRY_SET, a, 1'b1) >= 0) begin
          r.status = STATUS_EXISTS;
        end else begin
          // prefer a removed entry with the same address over a fresh one
          slot = find_slot(ENTRY_REMOVED, a, 1'b1);
          if (slot < 0) slot = find_slot(ENTRY_EMPTY, a, 1'b0);
          if (slot < 0) begin
            r.status = STATUS_FULL;
          end else begin
            tbl_state[slot] = ENTRY_SET;
            tbl_addr[slot]  = a;
          end
        end
      end
      FUNC_REMOVE: begin
        slot = find_slot(ENTRY_SET, a, 1'b1);
        if (slot < 0) r.status = STATUS_MISSING;
        else tbl_state[slot] = ENTRY_REMOVED;
      end
      FUNC_ACTIVATE: begin
        for (int i = 0; i < Entries; i++) begin
          if (tbl_state[i] == ENTRY_SET) begin
            // entries past the mask width have no failure bit
            if (i < MaskW && m[i % MaskW]) r.fails = r.fails + FailW'(1);
            else tbl_state[i] = ENTRY_ACTIVE;
          end
        end
      end
      FUNC_DEACTIVATE: begin
        for (int i = 0; i < Entries; i++)
          if (tbl_state[i] == ENTRY_ACTIVE) tbl_state[i] = ENTRY_SET;
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < Entries; i++) tbl_state[i] = ENTRY_EMPTY;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue_request(input logic [FuncW-1:0] f, input logic [AddrW-1:0] a,
                               input logic [MaskW-1:0] m, input bit fixed,
                               input reply_t fixed_reply);
    reply_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {m, a};
    s_axis_tuser  = f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_table_op(f, a, m);
    outstanding_replies.push_back(fixed ? fixed_reply : r);
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] pick_addr();
    if ($urandom_range(9) == 0) return $urandom;
    return addr_pool[$urandom_range(PoolSize - 1)];
  endfunction

  function automatic logic [MaskW-1:0] pick_mask();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return MaskW'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold whenever the stimulus asks for one.
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reply_count++;
      if (outstanding_replies.size() == 0) begin
        report_mismatch("unexpected reply", 32'(m_axis_tdata), 32'(0));
      end else begin
        got_reply = outstanding_replies.pop_front();
        if (m_axis_tdata[1:0] !== got_reply.status)
          report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(got_reply.status));
        if (m_axis_tdata[6:2] !== got_reply.fails)
          report_mismatch("fail_count", 32'(m_axis_tdata[6:2]), 32'(got_reply.fails));
        if (m_axis_tdata[7] !== 1'b0)
          report_mismatch("pad bit", 32'(m_axis_tdata[7]), 32'(0));
        status_seen[got_reply.status]++;
        if (int'(got_reply.fails) > peak_fails) peak_fails = int'(got_reply.fails);
      end
    end
  end

  initial begin
    reply_t          no_reply;
    reply_t          row_reply;
    int              phase_start;
    int              burst_len;
    int              base;
    bit              hold_done;
    int              pick;
    logic [FuncW-1:0] op;

    no_reply.status = STATUS_OK;
    no_reply.fails  = '0;
    hold_done       = 1'b0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < Entries; i++) begin
      tbl_state[i] = ENTRY_EMPTY;
      tbl_addr[i]  = '0;
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) addr_pool[i] = $urandom;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row_reply.status = DirectedRows[i].status;
      row_reply.fails  = DirectedRows[i].fails;
      issue_request(DirectedRows[i].func, DirectedRows[i].addr, DirectedRows[i].mask,
                    DirectedRows[i].fixed, row_reply);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      phase_start = sent_count;
      while (sent_count - phase_start < PhaseItems) begin
        // back up the output once while requests keep coming
        if (phase == 0 && !hold_done && sent_count - phase_start >= 100) begin
          hold_req++;
          hold_done = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
          // fill run: 14 to 20 sets in a row, which can run the table out of entries
          burst_len = $urandom_range(14, 20);
          base      = $urandom_range(PoolSize - 1);
          for (int k = 0; k < burst_len; k++)
            issue_request(FUNC_SET, addr_pool[(base + k) % PoolSize], pick_mask(), 1'b0,
                          no_reply);
          if ($urandom_range(1)) issue_request(FUNC_ACTIVATE, $urandom, '1, 1'b0, no_reply);
        end else begin
          if (pick < 46)      op = FUNC_SET;
          else if (pick < 68) op = FUNC_REMOVE;
          else if (pick < 78) op = FUNC_ACTIVATE;
          else if (pick < 88) op = FUNC_DEACTIVATE;
          else if (pick < 92) op = FUNC_CLEAR;
          else if (pick < 98) op = $urandom_range(1) ? FUNC_SET : FUNC_REMOVE;
          else                op = FuncW'($urandom_range(5, 7));
          issue_request(op, (pick >= 92 && pick < 98) ? $urandom : pick_addr(), pick_mask(),
                        1'b0, no_reply);
        end
      end
    end

    s_axis_tvalid = 1'b0;
    recv_stall_pct = 0;
    while (outstanding_replies.size() != 0) @(posedge clk_i);
    repeat (Entries + 8) @(posedge clk_i);

    $display("sw_breakpoint_table_tb: %0d requests, %0d replies", sent_count, reply_count);
    $display("  ok %0d, exists %0d, full %0d, missing %0d, peak failures %0d, %0d mismatches",
             status_seen[STATUS_OK], status_seen[STATUS_EXISTS], status_seen[STATUS_FULL],
             status_seen[STATUS_MISSING], peak_fails, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** sw_breakpoint_table: PASSED **");
    end else begin
      $display("** sw_breakpoint_table: FAILED **");
    end
    $finish;
  end

endmodule
